@@ hdl/ptlf_pkg.sv @@
// Package for pose_to_local_frame: payload widths, CORDIC constants and arctangent table.
// Used by the top level and its checker; depends on nothing else.
package ptlf_pkg;

    localparam int POS_W   = 32;   // Q16.16 position
    localparam int ANG_W   = 16;   // binary angle, full circle = 2^16
    localparam int DELTA_W = POS_W + 1;
    localparam int CS_W    = 32;   // Q2.30 sine and cosine in the CORDIC
    localparam int Z_W     = 32;   // CORDIC angle, full circle = 2^32
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_W  = 30;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [CS_W-1:0]  INV_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [SUM_W-1:0] HALF_Q30     = SUM_W'(64'sd536870912);
    localparam logic signed [ANG_W:0]   QUARTER_TURN = 17'sd16384;
    localparam logic signed [ANG_W:0]   HALF_TURN    = 17'sd32768;

    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [ANG_W-1:0]   t_ang;
    typedef logic signed [DELTA_W-1:0] t_delta;

    function automatic logic signed [Z_W-1:0] atan_q32(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933406;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10679838;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41721;
            15:      v = 32'sd20860;
            16:      v = 32'sd10430;
            17:      v = 32'sd5215;
            18:      v = 32'sd2607;
            19:      v = 32'sd1303;
            20:      v = 32'sd651;
            21:      v = 32'sd325;
            22:      v = 32'sd162;
            23:      v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/pose_to_local_frame.sv @@
// Pipeline, in order: deltas and fold, the CORDIC iterations, fold undo, products, sums, output.
// Throughput: one item per cycle; each stage does one of these steps (the four multiplies in one),
// so the pipeline takes a new item each cycle while unstalled.
// Stall: a waiting result on a stalled sink freezes the whole pipeline and shows on o_stall.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
// Depends on ptlf_pkg.
module pose_to_local_frame #(
    parameter int CORDIC_STEPS = 16   // 8 to 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input channel
    input  logic           i_valid,
    output logic           o_stall,
    input  ptlf_pkg::t_pos i_ref_x,
    input  ptlf_pkg::t_pos i_ref_y,
    input  ptlf_pkg::t_ang i_ref_heading,
    input  ptlf_pkg::t_pos i_target_x,
    input  ptlf_pkg::t_pos i_target_y,
    input  ptlf_pkg::t_ang i_target_heading,
    // output channel
    output logic           o_valid,
    input  logic           i_stall,
    output ptlf_pkg::t_pos o_local_x,
    output ptlf_pkg::t_pos o_local_y,
    output ptlf_pkg::t_ang o_local_heading
);
    import ptlf_pkg::*;

    localparam int N = CORDIC_STEPS;

    // Global advance: the pipeline moves unless a finished item waits on a stalled sink.
    // Bubbles still move forward, so nothing is lost or repeated.
    logic w_adv;
    logic r_out_valid;

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // ------------------------------------------------------------------
    // Stage 0: position deltas, heading difference, quadrant fold.
    // ------------------------------------------------------------------
    logic                  r_v    [0:N];
    t_delta                r_dx   [0:N];
    t_delta                r_dy   [0:N];
    t_ang                  r_dh   [0:N];
    logic                  r_flip [0:N];
    logic signed [CS_W-1:0] r_x   [0:N];
    logic signed [CS_W-1:0] r_y   [0:N];
    logic signed [Z_W-1:0]  r_z   [0:N];

    logic signed [ANG_W:0] w_h;
    logic signed [ANG_W:0] w_a;
    logic                  w_flip;

    assign w_h = {i_ref_heading[ANG_W-1], i_ref_heading};

    // Fold headings beyond a quarter turn by half a turn; negate sin/cos later.
    always_comb begin
        w_a    = w_h;
        w_flip = 1'b0;
        if (w_h > QUARTER_TURN) begin
            w_a    = w_h - HALF_TURN;
            w_flip = 1'b1;
        end else if (w_h < -QUARTER_TURN) begin
            w_a    = w_h + HALF_TURN;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx[0]   <= DELTA_W'(i_target_x) - DELTA_W'(i_ref_x);
            r_dy[0]   <= DELTA_W'(i_target_y) - DELTA_W'(i_ref_y);
            r_dh[0]   <= i_target_heading - i_ref_heading;
            r_flip[0] <= w_flip;
            r_x[0]    <= INV_GAIN_Q30;
            r_y[0]    <= '0;
            // folded angle fits 16 bits signed; scale to a 2^32 full circle
            r_z[0]    <= {w_a[ANG_W-1:0], 16'h0000};
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation: one iteration per stage, shift fixed by the stage.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < N; k++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dx[k+1]   <= r_dx[k];
                r_dy[k+1]   <= r_dy[k];
                r_dh[k+1]   <= r_dh[k];
                r_flip[k+1] <= r_flip[k];
                if (!r_z[k][Z_W-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q32(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q32(k);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Undo the quadrant fold: cos and sin in 33 bits.
    // ------------------------------------------------------------------
    logic                       r_cs_v;
    t_delta                     r_cs_dx, r_cs_dy;
    t_ang                       r_cs_dh;
    logic signed [DELTA_W-1:0]  r_cos, r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_v <= 1'b0;
        end else if (w_adv) begin
            r_cs_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cs_dx <= r_dx[N];
            r_cs_dy <= r_dy[N];
            r_cs_dh <= r_dh[N];
            if (r_flip[N]) begin
                r_cos <= -DELTA_W'(r_x[N]);
                r_sin <= -DELTA_W'(r_y[N]);
            end else begin
                r_cos <= DELTA_W'(r_x[N]);
                r_sin <= DELTA_W'(r_y[N]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Products: four 33x33 multiplies, registered.
    // ------------------------------------------------------------------
    logic                       r_p_v;
    t_ang                       r_p_dh;
    logic signed [PROD_W-1:0]   r_p_xc, r_p_ys, r_p_yc, r_p_xs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_adv) begin
            r_p_v <= r_cs_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_dh <= r_cs_dh;
            r_p_xc <= r_cs_dx * r_cos;
            r_p_ys <= r_cs_dy * r_sin;
            r_p_yc <= r_cs_dy * r_cos;
            r_p_xs <= r_cs_dx * r_sin;
        end
    end

    // ------------------------------------------------------------------
    // Rotate sums with the rounding half added.
    // ------------------------------------------------------------------
    logic                     r_s_v;
    t_ang                     r_s_dh;
    logic signed [SUM_W-1:0]  r_s_x, r_s_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (w_adv) begin
            r_s_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_dh <= r_p_dh;
            r_s_x  <= SUM_W'(r_p_xc) + SUM_W'(r_p_ys) + HALF_Q30;
            r_s_y  <= SUM_W'(r_p_yc) - SUM_W'(r_p_xs) + HALF_Q30;
        end
    end

    // ------------------------------------------------------------------
    // Scale down (floor), clamp to 32 bits, output register.
    // ------------------------------------------------------------------
    localparam int SH_W = SUM_W - FRAC_W;

    logic signed [SH_W-1:0] w_sh_x, w_sh_y;
    t_pos                   n_local_x, n_local_y;
    t_pos                   r_local_x, r_local_y;
    t_ang                   r_local_heading;

    assign w_sh_x = SH_W'(r_s_x >>> FRAC_W);
    assign w_sh_y = SH_W'(r_s_y >>> FRAC_W);

    function automatic t_pos sat_pos(input logic signed [SH_W-1:0] v);
        t_pos r;
        if (v > SH_W'(32'sh7fff_ffff)) begin
            r = 32'sh7fff_ffff;
        end else if (v < -SH_W'(64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    assign n_local_x = sat_pos(w_sh_x);
    assign n_local_y = sat_pos(w_sh_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_local_x       <= n_local_x;
            r_local_y       <= n_local_y;
            r_local_heading <= r_s_dh;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_local_x       = r_local_x;
    assign o_local_y       = r_local_y;
    assign o_local_heading = r_local_heading;

endmodule

@@ hdl/ptlf_checker.sv @@
// Port-level checks for pose_to_local_frame, bound to every instance of the top level.
// Depends on ptlf_pkg and pose_to_local_frame.
module ptlf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input ptlf_pkg::t_pos o_local_x,
    input ptlf_pkg::t_pos o_local_y,
    input ptlf_pkg::t_ang o_local_heading
);
    import ptlf_pkg::*;

    // reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // back pressure only ever comes from a waiting result on a stalled sink
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // a free sink never stalls the source
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    // a stalled result holds
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_local_x) && $stable(o_local_y)
                                  && $stable(o_local_heading)))
        else $error("stalled result changed");

endmodule

bind pose_to_local_frame ptlf_checker u_ptlf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_local_x       (o_local_x),
    .o_local_y       (o_local_y),
    .o_local_heading (o_local_heading)
);
